// ===== rtl/core/bounded_best_candidate_list_defines.svh =====
// Assertion macros used by the top level of the bounded best-candidate list.
`ifndef BOUNDED_BEST_CANDIDATE_LIST_DEFINES_SVH
`define BOUNDED_BEST_CANDIDATE_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BBCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BBCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bbcl_pkg.sv =====
// Package with widths, codes and types of the bounded best-candidate list.
package bbcl_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int MODE_W    = 2;
    localparam int QUALITY_W = 32;
    localparam int TAG_W     = 16;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_KEPT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_EMPT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

    // What one cell hands to its right-hand neighbour.
    typedef struct packed {
        logic                        found;
        logic signed [QUALITY_W-1:0] quality;
        logic [TAG_W-1:0]            tag;
    } bbcl_link_t;

    // Control that the top level gives each cell.
    typedef struct packed {
        logic insert_en;
        logic occupied;
    } bbcl_cell_ctrl_t;

endpackage

// ===== rtl/core/bbcl_in_if.sv =====
// Interface of the candidate input channel.
interface bbcl_in_if
    import bbcl_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [MODE_W-1:0]           mode;
    logic signed [QUALITY_W-1:0] quality;
    logic [TAG_W-1:0]            tag;
    logic [POS_W-1:0]            read_index;

    modport source (output valid, mode, quality, tag, read_index, input ready);
    modport sink (input valid, mode, quality, tag, read_index, output ready);
endinterface

// ===== rtl/core/bbcl_out_if.sv =====
// Interface of the result output channel.
interface bbcl_out_if
    import bbcl_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic [POS_W-1:0]            position;
    logic signed [QUALITY_W-1:0] out_quality;
    logic [TAG_W-1:0]            out_tag;
    logic [COUNT_W-1:0]          count;

    modport source (output valid, status, position, out_quality, out_tag, count, input ready);
    modport sink (input valid, status, position, out_quality, out_tag, count, output ready);
endinterface

// ===== rtl/core/bbcl_cell.sv =====
// One slot of the sorted list: compares, then keeps, takes the new item or shifts.
module bbcl_cell
    import bbcl_pkg::*;
(
    input  logic                        clk,
    input  bbcl_cell_ctrl_t             ctrl,
    input  logic signed [QUALITY_W-1:0] new_quality,
    input  logic [TAG_W-1:0]            new_tag,
    input  bbcl_link_t                  left,
    output bbcl_link_t                  right
);

    logic signed [QUALITY_W-1:0] quality_reg;
    logic [TAG_W-1:0]            tag_reg;
    logic                        take;

    // An empty slot always accepts, so an insert lands at the tail when no entry is lower or equal.
    assign take = !ctrl.occupied || (new_quality >= quality_reg);

    assign right.found   = left.found || take;
    assign right.quality = quality_reg;
    assign right.tag     = tag_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.insert_en)
        begin
            if (left.found)
            begin
                quality_reg <= left.quality;
                tag_reg     <= left.tag;
            end
            else if (take)
            begin
                quality_reg <= new_quality;
                tag_reg     <= new_tag;
            end
        end
    end

endmodule

// ===== rtl/core/bounded_best_candidate_list.sv =====
// Top level of the bounded best-candidate list: a row of compare-and-shift cells.
//
// Usage. Words arrive on the cand channel and carry a mode: insert a candidate
// (quality, tag), read the entry at read_index, or clear the list. Every insert,
// read and clear gives exactly one word on the result channel; mode 3 is taken
// and gives nothing. Each cell holds one entry; on an insert every cell
// compares the new quality with its own in parallel, the first cell that is
// lower or equal (or empty) takes the new item and every cell to its right
// takes its left-hand neighbour's entry, so the list stays in descending order.
// The whole step, search and shift, finishes in the cycle the word is taken.
// The result word is registered and valid in the cycle after acceptance.
// Throughput: one word per cycle while the receiver keeps ready high; the
// limit is the found chain that runs through all CAPACITY cells.
// The result sits in an output register; while it waits, cand.ready is low,
// and a new word is taken in the same cycle that the waiting result is taken.
// Reset empties the list at once (the count goes to zero; no clearing pass)
// and drops any result still waiting.
module bounded_best_candidate_list
    import bbcl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    bbcl_in_if.sink           cand,
    bbcl_out_if.source        result
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RD_SPAN = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Occupancy and the output register.
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [STATUS_W-1:0]         status_reg;
    logic [STATUS_W-1:0]         status_next;
    logic [POS_W-1:0]            position_reg;
    logic [POS_W-1:0]            position_next;
    logic signed [QUALITY_W-1:0] quality_reg;
    logic signed [QUALITY_W-1:0] quality_next;
    logic [TAG_W-1:0]            tag_reg;
    logic [TAG_W-1:0]            tag_next;

    logic                        accept;
    logic                        full;
    logic                        reject;
    logic                        read_ok;
    logic [IDX_W-1:0]            ins_pos;
    bbcl_link_t                  read_entry;
    bbcl_link_t                  links [CAPACITY+1];
    bbcl_cell_ctrl_t             cell_ctrl [CAPACITY];

    assign accept    = cand.valid && cand.ready;
    assign cand.ready = !out_valid_reg || result.ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));

    // The chain starts with nothing found; the left data of the first cell is unused.
    assign links[0] = '{found: 1'b0, quality: cand.quality, tag: cand.tag};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign cell_ctrl[gi].insert_en = accept && (cand.mode == MODE_INSERT) && !reject;
            assign cell_ctrl[gi].occupied  = (CNT_W'(gi) < count_reg);

            bbcl_cell u_cell
            (
                .clk         (clk),
                .ctrl        (cell_ctrl[gi]),
                .new_quality (cand.quality),
                .new_tag     (cand.tag),
                .left        (links[gi]),
                .right       (links[gi+1])
            );
        end
    endgenerate

    // No cell takes the item only when the list is full and every entry is higher.
    assign reject = !links[CAPACITY].found;

    // The landing slot is the one cell where the found chain turns on.
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (links[i+1].found && !links[i].found)
            begin
                ins_pos = ins_pos | IDX_W'(i);
            end
        end
    end

    // Only the first RD_SPAN slots, at most sixteen, can be addressed by a read.
    always_comb
    begin
        read_entry = links[1];
        for (int i = 0; i < RD_SPAN; i++)
        begin
            if (POS_W'(i) == cand.read_index)
            begin
                read_entry = links[i+1];
            end
        end
    end

    assign read_ok = (CMP_W'(cand.read_index) < CMP_W'(count_reg));

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        position_next  = position_reg;
        quality_next   = quality_reg;
        tag_next       = tag_reg;

        if (accept)
        begin
            out_valid_next = (cand.mode != MODE_NONE);
            unique case (cand.mode)
                MODE_INSERT:
                begin
                    if (reject)
                    begin
                        status_next   = ST_NOT_KEPT;
                        position_next = '0;
                        quality_next  = cand.quality;
                        tag_next      = cand.tag;
                    end
                    else if (full)
                    begin
                        status_next   = ST_DROPPED;
                        position_next = POS_W'(ins_pos);
                        quality_next  = links[CAPACITY].quality;
                        tag_next      = links[CAPACITY].tag;
                    end
                    else
                    begin
                        count_next    = CNT_W'(count_reg + 1'b1);
                        status_next   = ST_INSERTED;
                        position_next = POS_W'(ins_pos);
                        quality_next  = '0;
                        tag_next      = '0;
                    end
                end
                MODE_READ:
                begin
                    position_next = cand.read_index;
                    if (read_ok)
                    begin
                        status_next  = ST_READ_OK;
                        quality_next = read_entry.quality;
                        tag_next     = read_entry.tag;
                    end
                    else
                    begin
                        status_next  = ST_READ_EMPT;
                        quality_next = '0;
                        tag_next     = '0;
                    end
                end
                MODE_CLEAR:
                begin
                    count_next    = '0;
                    status_next   = ST_CLEARED;
                    position_next = '0;
                    quality_next  = '0;
                    tag_next      = '0;
                end
                default:
                begin
                    // Mode 3 leaves the list alone and gives no word.
                end
            endcase
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The count field reports the occupancy after the step.
    logic [COUNT_W-1:0] count_out_reg;

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        position_reg  <= position_next;
        quality_reg   <= quality_next;
        tag_reg       <= tag_next;
        count_out_reg <= COUNT_W'(count_next);
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = status_reg;
    assign result.position    = position_reg;
    assign result.out_quality = quality_reg;
    assign result.out_tag     = tag_reg;
    assign result.count       = count_out_reg;

`include "bounded_best_candidate_list_defines.svh"

    `BBCL_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `BBCL_ASSERT_NEXT(a_clear_empties, accept && (cand.mode == MODE_CLEAR), count_reg == '0, "clear did not empty the list")
    `BBCL_ASSERT_SAME(a_reject_when_full, accept && (cand.mode == MODE_INSERT) && reject, full, "insert refused on a list that is not full")
    `BBCL_ASSERT_NEXT(a_insert_grows, accept && (cand.mode == MODE_INSERT) && !full, count_reg == CNT_W'($past(count_reg) + 1'b1), "insert did not grow the list")

endmodule

// ===== test/tb_bounded_best_candidate_list.sv =====
// Self-checking testbench of the bounded best-candidate list, with a predictor of the sorted list.
`timescale 1ns / 100ps

module tb_bounded_best_candidate_list
    import bbcl_pkg::*;
();

    // The block is built with its default size, so the predictor keeps the same
    // number of slots.
    localparam int LIST_DEPTH      = CAPACITY_DEFAULT;
    localparam int PHASES          = 5;
    localparam int WORDS_PER_PHASE = 100;
    // Cycles that are let pass after the last result.
    localparam int SETTLE_CYCLES   = 4;
    // The slowest correct run sends at least 528 words, plus the drains between
    // phases. The limit is many times its length.
    localparam int CYCLE_LIMIT     = 200000;

    // One word on the result channel.
    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic [POS_W-1:0]            position;
        logic signed [QUALITY_W-1:0] quality;
        logic [TAG_W-1:0]            tag;
        logic [COUNT_W-1:0]          count;
    } result_word_t;

    // One row of the directed part. Where typed is set, the word that the row
    // must give is written out in the row itself; elsewhere it comes from the
    // predictor.
    typedef struct packed {
        logic [MODE_W-1:0]           mode;
        logic signed [QUALITY_W-1:0] quality;
        logic [TAG_W-1:0]            tag;
        logic [POS_W-1:0]            index;
        logic                        typed;
        result_word_t                want;
    } stim_row_t;

    localparam result_word_t NO_WORD = '0;
    localparam int DIRECTED_ROWS = 28;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bbcl_in_if  cand_ch ();
    bbcl_out_if res_ch ();

    bounded_best_candidate_list dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cand   (cand_ch),
        .result (res_ch)
    );

    always #6 clk = ~clk;

    // The predictor's own copy of the list, best entry at slot 0.
    logic signed [QUALITY_W-1:0] kept_quality [LIST_DEPTH];
    logic [TAG_W-1:0]            kept_tag [LIST_DEPTH];
    int                          kept_count = 0;

    // Words that the block owes, oldest first.
    result_word_t awaited_results [$];

    // When set, neither side idles: words go back to back in both directions.
    bit calm_phase = 1'b0;

    int mismatches      = 0;
    int results_checked = 0;
    int cycles          = 0;
    int stall_left      = 0;
    int words_taken [4];
    int status_seen [8];

    // The directed part. It opens on the empty list, tries both ends of the
    // quality range and a tie at the top, an ignored word, a read and a clear.
    // It then fills the list to the brim with ties in the middle and at the
    // tail, and pushes the full list through each of its outcomes: a new item
    // below everything that is not kept, a tie with the lowest entry that
    // displaces it, and a new best entry that drops the tail.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{MODE_READ,   32'sh0000_0000, 16'h0000, 4'd15, 1'b1,
          '{ST_READ_EMPT, 4'd15, 32'sh0000_0000, 16'h0000, 5'd0}},
        '{MODE_INSERT, 32'sh8000_0000, 16'h0000, 4'd0,  1'b1,
          '{ST_INSERTED,  4'd0,  32'sh0000_0000, 16'h0000, 5'd1}},
        '{MODE_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, 4'd0,  1'b1,
          '{ST_INSERTED,  4'd0,  32'sh0000_0000, 16'h0000, 5'd2}},
        '{MODE_INSERT, 32'sh7FFF_FFFF, 16'h00A5, 4'd0,  1'b1,
          '{ST_INSERTED,  4'd0,  32'sh0000_0000, 16'h0000, 5'd3}},
        '{MODE_NONE,   32'sh1234_5678, 16'h4321, 4'd9,  1'b1, NO_WORD},
        '{MODE_READ,   32'sh0000_0000, 16'h0000, 4'd2,  1'b1,
          '{ST_READ_OK,   4'd2,  32'sh8000_0000, 16'h0000, 5'd3}},
        '{MODE_CLEAR,  32'sh0000_0000, 16'h0000, 4'd0,  1'b1,
          '{ST_CLEARED,   4'd0,  32'sh0000_0000, 16'h0000, 5'd0}},
        '{MODE_INSERT, 32'sh0001_0000, 16'h0001, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'shFFFF_0000, 16'h0002, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh0001_0000, 16'h0003, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh7FFF_FFFF, 16'h0004, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh8000_0001, 16'h0005, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh0000_0000, 16'h0006, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'shFFFF_FFFF, 16'h0007, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh0000_8000, 16'h0008, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh4000_0000, 16'h0009, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'shC000_0000, 16'h000A, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh0000_0001, 16'h000B, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh8000_0001, 16'h000C, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh0001_0000, 16'h000D, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh7FFF_0000, 16'h000E, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'shFFFE_0000, 16'h000F, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh0002_0000, 16'h0010, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh8000_0000, 16'hBEEF, 4'd0,  1'b1,
          '{ST_NOT_KEPT,  4'd0,  32'sh8000_0000, 16'hBEEF, 5'd16}},
        '{MODE_INSERT, 32'sh8000_0001, 16'h0101, 4'd0,  1'b0, NO_WORD},
        '{MODE_INSERT, 32'sh7FFF_FFFF, 16'h5A5A, 4'd0,  1'b0, NO_WORD},
        '{MODE_READ,   32'sh0000_0000, 16'h0000, 4'd15, 1'b0, NO_WORD},
        '{MODE_CLEAR,  32'sh0000_0000, 16'h0000, 4'd0,  1'b1,
          '{ST_CLEARED,   4'd0,  32'sh0000_0000, 16'h0000, 5'd0}}
    };

    // Works out what the block must answer to one accepted word and moves the
    // predicted list on by that word. An ignored mode gives no word.
    task automatic forecast_word(input logic [MODE_W-1:0] mode,
                                 input logic signed [QUALITY_W-1:0] quality,
                                 input logic [TAG_W-1:0] tag,
                                 input logic [POS_W-1:0] index,
                                 output bit produces,
                                 output result_word_t word);
        int  slot;
        int  last;
        int  i;
        bit  found;
        bit  full;
        logic signed [QUALITY_W-1:0] lost_quality;
        logic [TAG_W-1:0]            lost_tag;

        produces = 1'b1;
        word     = NO_WORD;
        case (mode)
            MODE_INSERT:
            begin
                // The new item goes in front of the first entry that is no
                // better than it; with none such it joins the tail.
                slot  = kept_count;
                found = 1'b0;
                for (i = 0; i < LIST_DEPTH; i++)
                begin
                    if (!found && i < kept_count && quality >= kept_quality[i])
                    begin
                        slot  = i;
                        found = 1'b1;
                    end
                end
                if (slot >= LIST_DEPTH)
                begin
                    // The list is full and the newcomer is the worst of all.
                    word = '{ST_NOT_KEPT, '0, quality, tag, COUNT_W'(kept_count)};
                end
                else
                begin
                    full         = (kept_count == LIST_DEPTH);
                    lost_quality = '0;
                    lost_tag     = '0;
                    if (full)
                    begin
                        lost_quality = kept_quality[LIST_DEPTH-1];
                        lost_tag     = kept_tag[LIST_DEPTH-1];
                        last         = LIST_DEPTH - 1;
                    end
                    else
                    begin
                        last       = kept_count;
                        kept_count = kept_count + 1;
                    end
                    for (i = last; i > slot; i--)
                    begin
                        kept_quality[i] = kept_quality[i-1];
                        kept_tag[i]     = kept_tag[i-1];
                    end
                    kept_quality[slot] = quality;
                    kept_tag[slot]     = tag;
                    word = '{full ? ST_DROPPED : ST_INSERTED, POS_W'(slot),
                             lost_quality, lost_tag, COUNT_W'(kept_count)};
                end
            end
            MODE_READ:
            begin
                if (int'(index) < kept_count)
                    word = '{ST_READ_OK, index, kept_quality[index], kept_tag[index],
                             COUNT_W'(kept_count)};
                else
                    word = '{ST_READ_EMPT, index, '0, '0, COUNT_W'(kept_count)};
            end
            MODE_CLEAR:
            begin
                kept_count = 0;
                word = '{ST_CLEARED, '0, '0, '0, '0};
            end
            default:
                produces = 1'b0;
        endcase
    endtask

    // Offers one word on the candidate channel after a random gap and returns
    // at the edge where it is taken. The gap, when there is one, starts by
    // lowering valid, so valid never falls and rises within one step.
    task automatic push_word(input logic [MODE_W-1:0] mode,
                             input logic signed [QUALITY_W-1:0] quality,
                             input logic [TAG_W-1:0] tag,
                             input logic [POS_W-1:0] index,
                             input bit typed,
                             input result_word_t typed_word);
        int           gap;
        bit           produces;
        result_word_t forecast;

        gap = calm_phase ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            cand_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cand_ch.valid      <= 1'b1;
        cand_ch.mode       <= mode;
        cand_ch.quality    <= quality;
        cand_ch.tag        <= tag;
        cand_ch.read_index <= index;
        @(posedge clk);
        while (!cand_ch.ready)
            @(posedge clk);
        // Taken at this edge: the predictor moves on in the order of acceptance.
        forecast_word(mode, quality, tag, index, produces, forecast);
        words_taken[mode]++;
        if (produces)
            awaited_results.insert(awaited_results.size(),
                                   typed ? typed_word : forecast);
    endtask

    // Holds the sender back until every word owed has come, then lets the
    // latency pass so that an ignored last word has surely left the block.
    task automatic wait_for_results();
        cand_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Draws a random word. Inserts dominate and clears are rare, so the list
    // often fills up and overflows. Qualities come in equal parts from a small set
    // of values near zero, which gives many ties, and from the full range, and
    // otherwise from the extremes.
    task automatic draw_word(output logic [MODE_W-1:0] mode,
                             output logic signed [QUALITY_W-1:0] quality,
                             output logic [TAG_W-1:0] tag,
                             output logic [POS_W-1:0] index);
        int pick;
        int shade;

        pick = $urandom_range(0, 99);
        if (pick < 60)
            mode = MODE_INSERT;
        else if (pick < 92)
            mode = MODE_READ;
        else if (pick < 96)
            mode = MODE_CLEAR;
        else
            mode = MODE_NONE;

        shade = $urandom_range(0, 9);
        if (shade == 0)
            quality = 32'sh8000_0000;
        else if (shade == 1)
            quality = 32'sh7FFF_FFFF;
        else if (shade < 6)
            quality = (QUALITY_W'($urandom_range(0, 15)) - 32'sd8) <<< 16;
        else
            quality = $urandom;
        tag   = TAG_W'($urandom_range(0, 65535));
        index = POS_W'($urandom_range(0, 15));
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    // Result side: takes each word, compares it with the oldest one owed, and
    // then stalls for a random number of cycles before it is ready again.
    result_word_t owed;

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result word with nothing owed: status %0d, position %0d",
                       res_ch.status, res_ch.position);
                mismatches++;
            end
            else
            begin
                owed = awaited_results.pop_front();
                check_field("status", owed.status, res_ch.status);
                check_field("position", owed.position, res_ch.position);
                check_field("out_quality", owed.quality, res_ch.out_quality);
                check_field("out_tag", owed.tag, res_ch.out_tag);
                check_field("count", owed.count, res_ch.count);
                results_checked++;
                status_seen[owed.status]++;
            end
            stall_left = calm_phase ? 0 : $urandom_range(0, 3);
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
        end
        res_ch.ready <= (stall_left == 0);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d words still owed.",
                     cycles, awaited_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int                          r;
        int                          phase;
        int                          counted;
        stim_row_t                   row;
        logic [MODE_W-1:0]           mode;
        logic signed [QUALITY_W-1:0] quality;
        logic [TAG_W-1:0]            tag;
        logic [POS_W-1:0]            index;

        cand_ch.valid      = 1'b0;
        cand_ch.mode       = MODE_NONE;
        cand_ch.quality    = '0;
        cand_ch.tag        = '0;
        cand_ch.read_index = '0;

        // Reset is held low and released on a rising edge.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = directed_rows[r];
            push_word(row.mode, row.quality, row.tag, row.index, row.typed, row.want);
        end
        // The sender waits here until the list has answered every directed word.
        wait_for_results();

        // Random phases. The third runs with no idling on either side; the
        // sender drains the block between phases.
        for (phase = 0; phase < PHASES; phase++)
        begin
            calm_phase = (phase == 2);
            counted    = 0;
            while (counted < WORDS_PER_PHASE)
            begin
                draw_word(mode, quality, tag, index);
                push_word(mode, quality, tag, index, 1'b0, NO_WORD);
                if (mode != MODE_NONE)
                    counted++;
            end
            wait_for_results();
        end
        calm_phase = 1'b0;

        $display("Sent %0d inserts, %0d reads, %0d clears and %0d ignored words;",
                 words_taken[MODE_INSERT], words_taken[MODE_READ],
                 words_taken[MODE_CLEAR], words_taken[MODE_NONE]);
        $display("%0d results checked. Inserts: %0d kept, %0d dropping the tail, %0d not kept; %0d reads past the end.",
                 results_checked, status_seen[ST_INSERTED], status_seen[ST_DROPPED],
                 status_seen[ST_NOT_KEPT], status_seen[ST_READ_EMPT]);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bbcl_pkg.sv
rtl/core/bbcl_in_if.sv
rtl/core/bbcl_out_if.sv
rtl/core/bbcl_cell.sv
rtl/core/bounded_best_candidate_list.sv
test/tb_bounded_best_candidate_list.sv
